[hw/rtl/sdl_pkg.sv]
// Package: shared types and constants for the sorted descending list.
`timescale 1ns / 1ps

package sdl_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned PAY_W = 64;
  localparam int unsigned POS_W = 6;
  localparam int unsigned LEN_W = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_POS = 2'd2
  } status_e;

  typedef struct packed {
    op_e                     op;
    logic [PAY_W-1:0]        payload;
    logic signed [KEY_W-1:0] sort_value;
    logic [POS_W-1:0]        position;
  } req_t;

  typedef struct packed {
    status_e                 status;
    logic [PAY_W-1:0]        out_payload;
    logic signed [KEY_W-1:0] out_value;
    logic [LEN_W-1:0]        length;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_READ,
    S_INS_CMP,
    S_INS_HEAD,
    S_DEL_READ,
    S_DEL_WRITE,
    S_GET_READ,
    S_GET_RESP
  } state_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_LAST,
    PTR_POS,
    PTR_DEC,
    PTR_INC
  } ptr_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_SHIFT_UP,
    WR_SHIFT_DOWN,
    WR_NEW_NEXT,
    WR_NEW_HEAD
  } wr_sel_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_PTR,
    RD_NEXT
  } rd_sel_e;

  typedef struct packed {
    logic    load;
    ptr_op_e ptr_op;
    cnt_op_e cnt_op;
    wr_sel_e wr_sel;
    rd_sel_e rd_sel;
    logic    resp;
    status_e resp_status;
    logic    resp_data;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic full;
    logic empty;
    logic bad_pos;
    logic pos_last;
    logic ptr_zero;
    logic ptr_last;
    logic greater;
  } sts_t;

endpackage

[hw/rtl/sdl_ctrl.sv]
// Controller: sequences insert, delete, get and clear requests.
`timescale 1ns / 1ps

module sdl_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  sdl_pkg::sts_t sts_i,
  output sdl_pkg::cmd_t cmd_o
);
  import sdl_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.ptr_op      = PTR_HOLD;
    cmd_o.cnt_op      = CNT_HOLD;
    cmd_o.wr_sel      = WR_NONE;
    cmd_o.rd_sel      = RD_NONE;
    cmd_o.resp_status = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        case (sts_i.op)
          OP_INSERT: begin
            if (sts_i.full) begin
              cmd_o.resp        = 1'b1;
              cmd_o.resp_status = ST_FULL;
            end else if (sts_i.empty) begin
              cmd_o.wr_sel = WR_NEW_HEAD;
              cmd_o.cnt_op = CNT_INC;
              cmd_o.resp   = 1'b1;
            end else begin
              cmd_o.ptr_op = PTR_LAST;
              state_d      = S_INS_READ;
            end
          end
          OP_DELETE: begin
            if (sts_i.bad_pos) begin
              cmd_o.resp        = 1'b1;
              cmd_o.resp_status = ST_BAD_POS;
            end else if (sts_i.pos_last) begin
              cmd_o.cnt_op = CNT_DEC;
              cmd_o.resp   = 1'b1;
            end else begin
              cmd_o.ptr_op = PTR_POS;
              state_d      = S_DEL_READ;
            end
          end
          OP_GET: begin
            if (sts_i.bad_pos) begin
              cmd_o.resp        = 1'b1;
              cmd_o.resp_status = ST_BAD_POS;
            end else begin
              cmd_o.ptr_op = PTR_POS;
              state_d      = S_GET_READ;
            end
          end
          default: begin
            cmd_o.cnt_op = CNT_CLR;
            cmd_o.resp   = 1'b1;
          end
        endcase
      end
      S_INS_READ: begin
        cmd_o.rd_sel = RD_PTR;
        state_d      = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (sts_i.greater) begin
          cmd_o.wr_sel = WR_SHIFT_UP;
          if (sts_i.ptr_zero) begin
            state_d = S_INS_HEAD;
          end else begin
            cmd_o.ptr_op = PTR_DEC;
            state_d      = S_INS_READ;
          end
        end else begin
          cmd_o.wr_sel = WR_NEW_NEXT;
          cmd_o.cnt_op = CNT_INC;
          cmd_o.resp   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_INS_HEAD: begin
        cmd_o.wr_sel = WR_NEW_HEAD;
        cmd_o.cnt_op = CNT_INC;
        cmd_o.resp   = 1'b1;
        state_d      = S_IDLE;
      end
      S_DEL_READ: begin
        cmd_o.rd_sel = RD_NEXT;
        state_d      = S_DEL_WRITE;
      end
      S_DEL_WRITE: begin
        cmd_o.wr_sel = WR_SHIFT_DOWN;
        if (sts_i.ptr_last) begin
          cmd_o.cnt_op = CNT_DEC;
          cmd_o.resp   = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.ptr_op = PTR_INC;
          state_d      = S_DEL_READ;
        end
      end
      S_GET_READ: begin
        cmd_o.rd_sel = RD_PTR;
        state_d      = S_GET_RESP;
      end
      S_GET_RESP: begin
        cmd_o.resp      = 1'b1;
        cmd_o.resp_data = 1'b1;
        state_d         = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/sdl_datapath.sv]
// Datapath: entry memory, pointer, entry count and result register.
`timescale 1ns / 1ps

module sdl_datapath #(
  parameter int unsigned CAPACITY      = 64,
  parameter int unsigned PAYLOAD_WIDTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sdl_pkg::req_t req_i,
  input  sdl_pkg::cmd_t cmd_i,
  output sdl_pkg::sts_t sts_o,
  output sdl_pkg::res_t res_o,
  output logic          res_valid_o
);
  import sdl_pkg::*;

  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > POS_W + 1) ? CW : POS_W + 1;
  localparam int unsigned WW   = KEY_W + PAYLOAD_WIDTH;

  logic [WW-1:0] entry_mem_q [CAPACITY];
  logic [WW-1:0] rdata_q;
  req_t          req_q;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  res_t          res_q, res_d;
  logic          res_valid_q;

  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [WW-1:0]           wr_data;
  logic [AW-1:0]           ptr_next;
  logic [WW-1:0]           new_word;
  logic signed [KEY_W-1:0] rkey;

  assign ptr_next = ptr_q + AW'(1);
  assign new_word = {req_q.sort_value, req_q.payload[PAYLOAD_WIDTH-1:0]};
  assign rkey     = rdata_q[PAYLOAD_WIDTH +: KEY_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  always_comb begin
    sts_o.op       = req_q.op;
    sts_o.full     = (cnt_q == CW'(CAPACITY));
    sts_o.empty    = (cnt_q == '0);
    sts_o.bad_pos  = (CMPW'(req_q.position) >= CMPW'(cnt_q));
    sts_o.pos_last = ((CMPW'(req_q.position) + CMPW'(1)) == CMPW'(cnt_q));
    sts_o.ptr_zero = (ptr_q == '0);
    sts_o.ptr_last = ((CW'(ptr_q) + CW'(2)) == cnt_q);
    sts_o.greater  = (req_q.sort_value > rkey);
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr_q;
    case (cmd_i.rd_sel)
      RD_PTR: begin
        rd_en = 1'b1;
      end
      RD_NEXT: begin
        rd_en   = 1'b1;
        rd_addr = ptr_next;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = ptr_q;
    wr_data = rdata_q;
    case (cmd_i.wr_sel)
      WR_SHIFT_UP: begin
        wr_addr = ptr_next;
      end
      WR_SHIFT_DOWN: begin
        wr_addr = ptr_q;
      end
      WR_NEW_NEXT: begin
        wr_addr = ptr_next;
        wr_data = new_word;
      end
      WR_NEW_HEAD: begin
        wr_addr = '0;
        wr_data = new_word;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= entry_mem_q[rd_addr];
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    case (cmd_i.ptr_op)
      PTR_LAST: ptr_d = AW'(cnt_q - CW'(1));
      PTR_POS:  ptr_d = AW'(req_q.position);
      PTR_DEC:  ptr_d = ptr_q - AW'(1);
      PTR_INC:  ptr_d = ptr_next;
      default:  ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    case (cmd_i.cnt_op)
      CNT_INC: cnt_d = cnt_q + CW'(1);
      CNT_DEC: cnt_d = cnt_q - CW'(1);
      CNT_CLR: cnt_d = '0;
      default: cnt_d = cnt_q;
    endcase
  end

  always_comb begin
    res_d.status      = cmd_i.resp_status;
    res_d.out_payload = '0;
    res_d.out_value   = '0;
    res_d.length      = LEN_W'(cnt_d);
    if (cmd_i.resp_data) begin
      res_d.out_payload = PAY_W'(rdata_q[PAYLOAD_WIDTH-1:0]);
      res_d.out_value   = rkey;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      res_valid_q <= cmd_i.resp;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.resp) begin
      res_q <= res_d;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

[hw/rtl/sorted_descending_list.sv]
// Top level: sorted descending list, controller plus datapath.
// From request to result strobe: clear, full and bad position answer at decode;
// get reads then responds; delete and insert read, then write, each entry visited.
// One request at a time; busy stays high until the result register is loaded.
// The entry memory has one write and one read port; insert at the head adds a write.
// Reset empties the list; entry memory is not cleared. The receiver cannot stall.
`timescale 1ns / 1ps

module sorted_descending_list #(
  parameter int unsigned CAPACITY      = 64,
  parameter int unsigned PAYLOAD_WIDTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  sdl_pkg::req_t req_i,
  output sdl_pkg::res_t res_o,
  output logic          res_valid_o
);
  import sdl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sdl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  sdl_datapath #(
    .CAPACITY      (CAPACITY),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule
